// ----- hw/rtl/ftda_pkg.sv -----
// Package: shared constants, types and state encoding for the fixed-to-decimal block.
`default_nettype none

package ftda_pkg;

   // Fixed-point format and text limits
   localparam int INT_BITS        = 16;
   localparam int FRAC_BITS       = 16;
   localparam int MAX_FRAC_DIGITS = 4;

   // Port field widths
   localparam int VALUE_W = 32;
   localparam int CFG_W   = 3;
   localparam int CHAR_W  = 8;

   localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(2);
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

   // Count decimal digits needed for the largest integer part
   function automatic int dec_digits(input int bits);
      longint max_val;
      longint p;
      int     n;
      max_val = (longint'(1) << bits) - 1;
      p = 1;
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (p <= max_val) begin
            n++;
            p = p * 10;
         end
      end
      return n;
   endfunction

   localparam int INT_DIGITS = dec_digits(INT_BITS);
   localparam int STEPS      = (INT_BITS + 3) / 4;
   localparam int CONV_W     = STEPS * 4;
   localparam int BCD_W      = INT_DIGITS * 4;
   localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W      = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
   localparam int FD_W       = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int EXT_W      = INT_BITS + FRAC_BITS + VALUE_W;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [FD_W-1:0]    digits;
   } ftda_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ftda_qstat_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CONV,
      B_SCAN,
      B_INT,
      B_DOT,
      B_FRAC
   } ftda_bstate_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ftda_if.sv -----
// Interfaces: request (fixed-point value) and response (character stream) channels.
`default_nettype none

interface ftda_req_if import ftda_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface ftda_rsp_if import ftda_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ftda_queue.sv -----
// Module: short job queue decoupling the front end from the conversion back end.
`default_nettype none

module ftda_queue import ftda_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  ftda_job_type      push_job,
   input  wire logic         pop,
   output ftda_job_type      pop_job,
   output ftda_qstat_type    stat
);

   ftda_job_type           ents_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_job    = ents_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         ents_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> !pop)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !stat.full) |=> !stat.empty)
      else $error("queue lost a pushed job");

endmodule

`default_nettype wire

// ----- hw/rtl/ftda_front.sv -----
// Module: front end; holds the digit-count register and queues accepted values.
`default_nettype none

module ftda_front import ftda_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   ftda_req_if.sink              req,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data,
   input  ftda_qstat_type        qstat,
   output logic                  push,
   output ftda_job_type          push_job
);

   logic [CFG_W-1:0] digits_cfg_ff, digits_cfg_in;

   // Write the digit-count register
   always_comb begin
      digits_cfg_in = digits_cfg_ff;
      if (csr_wr_en) begin
         digits_cfg_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_cfg_ff <= CFG_RESET;
      end else begin
         digits_cfg_ff <= digits_cfg_in;
      end
   end

   // Accept a transaction whenever the queue has room
   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   // Tag the value with its clamped digit count
   always_comb begin
      push_job.value = req.value;
      if (int'(digits_cfg_ff) > MAX_FRAC_DIGITS) begin
         push_job.digits = FD_W'(MAX_FRAC_DIGITS);
      end else begin
         push_job.digits = FD_W'(digits_cfg_ff);
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ftda_back.sv -----
// Module: back end; converts a queued value to decimal and streams its characters.
`default_nettype none

module ftda_back import ftda_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  ftda_qstat_type qstat,
   input  ftda_job_type   pop_job,
   output logic           pop,
   ftda_rsp_if.source     rsp
);

   ftda_bstate_type       state_ff, state_in;
   logic [CONV_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [FD_W-1:0]       digits_ff, digits_in;
   logic [FD_W-1:0]       fcnt_ff, fcnt_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;

   logic                  can_emit;
   logic                  emit;
   logic [EXT_W-1:0]      job_ext;
   logic [BCD_W-1:0]      bcd_step;
   logic [CONV_W-1:0]     bin_step;
   logic [IDX_W-1:0]      lead_idx;
   logic [FRAC_BITS+3:0]  frac_x10;
   logic [3:0]            int_digit;

   assign can_emit = !out_valid_ff || rsp.ready;
   assign job_ext  = EXT_W'(pop_job.value);

   // Shift four integer bits into the BCD digits, adjusting before each shift
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int b = 0; b < 4; b++) begin
         for (int i = 0; i < INT_DIGITS; i++) begin
            if (bcd_step[i*4 +: 4] >= 4'd5) begin
               bcd_step[i*4 +: 4] = bcd_step[i*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_W-2:0], bin_step[CONV_W-1]};
         bin_step = {bin_step[CONV_W-2:0], 1'b0};
      end
   end

   // Locate the most significant nonzero digit
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < INT_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   assign int_digit = bcd_ff[idx_ff*4 +: 4];
   assign frac_x10  = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!qstat.empty) state_in = B_CONV;
         end
         B_CONV: begin
            if (step_ff == STEP_W'(STEPS - 1)) state_in = B_SCAN;
         end
         B_SCAN: state_in = B_INT;
         B_INT: begin
            if (can_emit && idx_ff == '0) begin
               state_in = (digits_ff == '0) ? B_IDLE : B_DOT;
            end
         end
         B_DOT: begin
            if (can_emit) state_in = B_FRAC;
         end
         B_FRAC: begin
            if (can_emit && fcnt_ff == '0) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pop         = 1'b0;
      emit        = 1'b0;
      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      frac_in     = frac_ff;
      digits_in   = digits_ff;
      fcnt_in     = fcnt_ff;
      step_in     = step_ff;
      idx_in      = idx_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!qstat.empty) begin
               pop       = 1'b1;
               bin_in    = CONV_W'(job_ext[FRAC_BITS +: INT_BITS]);
               bcd_in    = '0;
               frac_in   = job_ext[FRAC_BITS-1:0];
               digits_in = pop_job.digits;
               step_in   = '0;
            end
         end
         B_CONV: begin
            bin_in  = bin_step;
            bcd_in  = bcd_step;
            step_in = step_ff + 1'b1;
         end
         B_SCAN: begin
            idx_in = lead_idx;
         end
         B_INT: begin
            if (can_emit) begin
               emit        = 1'b1;
               out_char_in = CHAR_ZERO + CHAR_W'(int_digit);
               out_last_in = (idx_ff == '0) && (digits_ff == '0);
               if (idx_ff != '0) idx_in = idx_ff - 1'b1;
            end
         end
         B_DOT: begin
            if (can_emit) begin
               emit        = 1'b1;
               out_char_in = CHAR_DOT;
               out_last_in = 1'b0;
               fcnt_in     = digits_ff - 1'b1;
            end
         end
         B_FRAC: begin
            if (can_emit) begin
               emit        = 1'b1;
               out_char_in = CHAR_ZERO + CHAR_W'(frac_x10[FRAC_BITS +: 4]);
               out_last_in = (fcnt_ff == '0);
               frac_in     = frac_x10[FRAC_BITS-1:0];
               if (fcnt_ff != '0) fcnt_in = fcnt_ff - 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      out_valid_in = emit || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload registers without reset
   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      frac_ff     <= frac_in;
      digits_ff   <= digits_in;
      fcnt_ff     <= fcnt_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.character = out_char_ff;
   assign rsp.last      = out_last_ff;

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == B_IDLE) && !qstat.empty)
      else $error("job popped outside idle state");

   a_frac_needs_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FRAC || state_ff == B_DOT) |-> (digits_ff != '0))
      else $error("fraction emitted with zero digit count");

   a_conv_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CONV && step_ff == STEP_W'(STEPS - 1)) |=> (state_ff == B_SCAN))
      else $error("conversion did not finish after its step count");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_valid_ff || rsp.ready))
      else $error("character overwrote a pending response");

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_to_decimal_ascii.sv -----
// Top level: unsigned fixed-point value to decimal ASCII character stream.
//
// Usage:
//  - req channel: one transaction carries a 32-bit unsigned 16.16 value.
//  - rsp channel: the value's text, one character per transaction, most
//    significant first; last marks the final character. Text is the integer
//    part without leading zeros ('0' for zero), then, when the digit count is
//    nonzero, a '.' and that many truncated fraction digits.
//  - csr_wr_en/csr_wr_data set the fraction digit count (0..4, larger values
//    act as 4). Write only while no value is in flight.
//  - The back end takes one queued value at a time: a 4-bit-per-cycle BCD
//    conversion (4 steps), then its N characters (1..10) one per cycle
//    through the output register while the receiver does not stall.
//  - A two-entry queue lets req accept while the back end works.
//  - Reset empties the queue, clears the output valid flag and sets the digit count to 2.
//  - When the receiver stalls, the character is held and the back end waits.
`default_nettype none

module fixed_to_decimal_ascii import ftda_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   ftda_req_if.sink              req,
   ftda_rsp_if.source            rsp,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   logic           push;
   logic           pop;
   ftda_job_type   push_job;
   ftda_job_type   pop_job;
   ftda_qstat_type qstat;

   ftda_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .push        (push),
      .push_job    (push_job)
   );

   ftda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .stat     (qstat)
   );

   ftda_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .pop_job (pop_job),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire

// ----- tb/sv/fixed_to_decimal_ascii_tb.sv -----
// Testbench: checks the fixed-point to decimal text block against a built-in text predictor.
`timescale 1ns / 100ps

module fixed_to_decimal_ascii_tb;
   import ftda_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } text_char_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   ftda_req_if req_if ();
   ftda_rsp_if rsp_if ();

   fixed_to_decimal_ascii dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Values waiting to be offered, characters still owed by the block
   logic [VALUE_W-1:0] pending_values[$];
   text_char_type      expected_text[$];

   logic [CFG_W-1:0] frac_digits_cfg;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int unsigned      values_accepted;
   int unsigned      stall_left;
   logic             stall_done;
   int unsigned      error_count;

   // Append the decimal text of one value to the expected characters
   function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                        input logic [CFG_W-1:0] cfg);
      logic [INT_BITS-1:0]  whole;
      logic [FRAC_BITS-1:0] frac;
      logic [63:0]          scale;
      logic [63:0]          frac_scaled;
      logic [CHAR_W-1:0]    int_chars[$];
      logic [CHAR_W-1:0]    frac_chars[$];
      logic [CHAR_W-1:0]    line[$];
      text_char_type        c;
      int                   d;
      int                   i;
      whole = v[FRAC_BITS +: INT_BITS];
      frac  = v[FRAC_BITS-1:0];
      d = (cfg > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(cfg);
      // integer part, no leading zeros, a lone zero when the part is zero
      do begin
         int_chars.push_front(CHAR_ZERO + CHAR_W'(whole % 10));
         whole = INT_BITS'(whole / 10);
      end while (whole != 0);
      line = int_chars;
      // truncated fraction, zero-padded to d digits
      if (d != 0) begin
         scale = 64'd1;
         for (i = 0; i < d; i++) begin
            scale = scale * 10;
         end
         frac_scaled = (64'(frac) * scale) >> FRAC_BITS;
         for (i = 0; i < d; i++) begin
            frac_chars.push_front(CHAR_ZERO + CHAR_W'(frac_scaled % 10));
            frac_scaled = frac_scaled / 10;
         end
         line.push_back(CHAR_DOT);
         for (i = 0; i < frac_chars.size(); i++) begin
            line.push_back(frac_chars[i]);
         end
      end
      for (i = 0; i < line.size(); i++) begin
         c.character = line[i];
         c.last = (i == line.size() - 1);
         expected_text.push_back(c);
      end
   endfunction

   // Pick a value: fully random, near digit-count boundaries, or small parts
   function automatic logic [VALUE_W-1:0] rand_value();
      logic [INT_BITS-1:0]  whole;
      logic [FRAC_BITS-1:0] frac;
      logic [INT_BITS-1:0]  edges[8];
      edges = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd9999, 16'd10000, 16'd65535};
      case ($urandom_range(3))
         0: begin
            return $urandom;
         end
         1: begin
            whole = edges[$urandom_range(7)];
            frac  = FRAC_BITS'($urandom);
         end
         2: begin
            whole = INT_BITS'($urandom_range(99));
            case ($urandom_range(2))
               0: frac = '0;
               1: frac = '1;
               default: frac = FRAC_BITS'($urandom);
            endcase
         end
         default: begin
            whole = INT_BITS'($urandom_range(1000));
            frac  = FRAC_BITS'($urandom_range(15));
         end
      endcase
      return {whole, frac};
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver: offer queued values, predict the text on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_text(req_if.value, frac_digits_cfg);
            values_accepted <= values_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.value <= pending_values.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once, while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && values_accepted == 180) begin
         stall_left <= 120;
         stall_done <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Response monitor: compare each character with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected transaction, got char %h last %b",
                        $time, rsp_if.character, rsp_if.last);
               error_count <= error_count + 1;
            end else if (rsp_if.character !== expected_text[0].character ||
                         rsp_if.last !== expected_text[0].last) begin
               $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                        $time, expected_text[0].character, expected_text[0].last,
                        rsp_if.character, rsp_if.last);
               error_count <= error_count + 1;
               void'(expected_text.pop_front());
            end else begin
               void'(expected_text.pop_front());
            end
         end
         rsp_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hold until every value is sent and every character has come back
   task automatic wait_drained();
      while (pending_values.size() != 0 || req_if.valid || expected_text.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the digit-count register while the block is idle
   task automatic write_digits(input logic [CFG_W-1:0] d);
      wait_drained();
      @(posedge clock);
      csr_wr_en       <= 1'b1;
      csr_wr_data     <= d;
      frac_digits_cfg <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Stimulus and end of run
   initial begin
      logic [CFG_W-1:0] block_digits[10];
      block_digits = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd0, 3'd4, 3'd6};
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_if.valid    = 1'b0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      frac_digits_cfg = CFG_RESET;
      send_idle_pct   = 12;
      recv_idle_pct   = 53;
      values_accepted = 0;
      error_count     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, zero integer part, digit count above the maximum
      pending_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
                         32'hFFFF_0000, 32'h0009_8000, 32'h000A_0000};
      write_digits(3'd0);
      pending_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0063_4000,
                         32'h0064_0000, 32'h270F_C000, 32'h2710_0001};
      write_digits(3'd4);
      pending_values = '{32'h0000_0001, 32'h0000_FFFF, 32'h0000_8000,
                         32'hFFFF_FFFF, 32'h0001_1999, 32'h0000_0000};
      write_digits(3'd7);
      pending_values = '{32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0003_0001, 32'h0000_0000};
      write_digits(3'd1);
      pending_values = '{32'h0000_FFFF, 32'h0000_199A, 32'hFFFF_0000};

      // Random blocks: sender light / receiver heavy, then swapped, then none
      for (int b = 0; b < 10; b++) begin
         write_digits(block_digits[b]);
         if (b < 3) begin
            set_idling(12, 53);
         end else if (b < 6) begin
            set_idling(53, 12);
         end else begin
            set_idling(0, 0);
         end
         for (int n = 0; n < 21; n++) begin
            pending_values.push_back(rand_value());
         end
      end
      wait_drained();
      repeat (30) @(posedge clock);

      if (error_count == 0 && expected_text.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ftda_pkg.sv
hw/rtl/ftda_if.sv
hw/rtl/ftda_queue.sv
hw/rtl/ftda_front.sv
hw/rtl/ftda_back.sv
hw/rtl/fixed_to_decimal_ascii.sv
tb/sv/fixed_to_decimal_ascii_tb.sv
